### src/olafr_pkg.sv
// ----------------------------------------------------------------------------
// Ordered key list package
// Shared types, codes and defaults for the ordered key list block.
// ----------------------------------------------------------------------------
package olafr_pkg;

    // default number of list entries
    localparam int OLAFR_DEPTH = 16;

    // key width
    localparam int KEY_W = 32;

    // request kinds
    localparam logic [1:0] KIND_APPEND = 2'd0;
    localparam logic [1:0] KIND_FIND   = 2'd1;
    localparam logic [1:0] KIND_REMOVE = 2'd2;

    // result status codes
    localparam logic [1:0] STAT_OK      = 2'd0;
    localparam logic [1:0] STAT_MISSING = 2'd1;
    localparam logic [1:0] STAT_FULL    = 2'd2;

    // one request item
    typedef struct packed {
        logic [1:0]              kind;
        logic signed [KEY_W-1:0] key;
    } t_request;

    // one result item
    typedef struct packed {
        logic [1:0] status;
        logic       found;
        logic [3:0] position;
        logic [4:0] count;
    } t_result;

    // sequencer commands to the walk unit
    typedef struct packed {
        logic load;
        logic run;
    } t_walk_ctrl;

    // walk unit status back to the sequencer
    typedef struct packed {
        logic hit;
        logic pend;
        logic drained;
    } t_walk_stat;

endpackage

### src/olafr_ram.sv
// ----------------------------------------------------------------------------
// Generic single-port-write RAM
// One write port and one read port with registered read data.
// ----------------------------------------------------------------------------
module olafr_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 16
) (
    input  logic                                   i_clk,
    input  logic                                   i_we,
    input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] i_waddr,
    input  logic [WIDTH-1:0]                       i_wdata,
    input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] i_raddr,
    output logic [WIDTH-1:0]                       o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    // write the addressed word
    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
    end

    // register the read word
    always_ff @(posedge i_clk) begin
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;

endmodule

### src/olafr_walk.sv
// ----------------------------------------------------------------------------
// Ordered key list walk unit
// Shared read pointer and key comparator, stepping one entry a cycle
// through the list RAM for both the search and the shift-down pass.
// ----------------------------------------------------------------------------
module olafr_walk #(
    parameter int DEPTH = olafr_pkg::OLAFR_DEPTH
) (
    input  logic                                       i_clk,
    input  logic                                       i_rst_n,
    input  olafr_pkg::t_walk_ctrl                      i_ctrl,
    input  logic [$clog2(DEPTH+1)-1:0]                 i_base,
    input  logic [$clog2(DEPTH+1)-1:0]                 i_limit,
    input  logic [olafr_pkg::KEY_W-1:0]                i_key,
    input  logic [olafr_pkg::KEY_W-1:0]                i_rd_data,
    output logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] o_rd_addr,
    output logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] o_tag,
    output olafr_pkg::t_walk_stat                      o_stat
);

    import olafr_pkg::*;

    localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int FW = $clog2(DEPTH + 1);

    logic [FW-1:0] r_ptr, n_ptr;
    logic          r_pend, n_pend;
    logic [AW-1:0] r_tag, n_tag;
    logic          w_more;

    // more entries left below the limit
    assign w_more = (r_ptr < i_limit);

    // advance the pointer, tag the word in flight
    always_comb begin
        n_ptr  = r_ptr;
        n_pend = 1'b0;
        n_tag  = r_tag;
        if (i_ctrl.load) begin
            n_ptr = i_base;
        end else if (i_ctrl.run && w_more) begin
            n_pend = 1'b1;
            n_tag  = r_ptr[AW-1:0];
            n_ptr  = r_ptr + FW'(1);
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_ptr  <= '0;
            r_pend <= 1'b0;
        end else begin
            r_ptr  <= n_ptr;
            r_pend <= n_pend;
        end
    end

    always_ff @(posedge i_clk) begin
        r_tag <= n_tag;
    end

    // compare the returned word against the key
    assign o_rd_addr      = r_ptr[AW-1:0];
    assign o_tag          = r_tag;
    assign o_stat.hit     = r_pend && (i_rd_data == i_key);
    assign o_stat.pend    = r_pend;
    assign o_stat.drained = !r_pend && !w_more;

endmodule

### src/ordered_list_append_find_remove_top.sv
// ----------------------------------------------------------------------------
// Ordered key list top level
// Sequencer, fill count and result register around the list RAM and walk.
// ----------------------------------------------------------------------------
// Usage: drive a request on i_req and pulse start while busy is low; the
// item is taken at that clock edge. Each item gives exactly one result on
// o_res, held for one cycle and marked by o_valid; the receiver cannot stall
// and must take it in that cycle.
// Append, an unused kind, and find or remove on an empty list need no walk:
// the result appears the cycle after the item is taken and busy stays
// low, so a new item may follow at once.
// Find walks the list through the single RAM read port, one entry a cycle.
// Remove adds a shift-down pass over the later entries, again one a cycle
// through the same port. busy is high from the cycle after the item is
// taken until the cycle in which the result is shown.
// Reset (synchronous, active low) empties the list; entry contents are not
// cleared and are only read once written.
// ----------------------------------------------------------------------------
module ordered_list_append_find_remove_top #(
    parameter int DEPTH = olafr_pkg::OLAFR_DEPTH
) (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                start,
    input  olafr_pkg::t_request i_req,
    output logic                busy,
    output logic                o_valid,
    output olafr_pkg::t_result  o_res
);

    import olafr_pkg::*;

    localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int FW = $clog2(DEPTH + 1);
    localparam logic [FW-1:0] FILL_MAX = FW'(DEPTH);

    // sequencer states
    localparam logic [1:0] ST_IDLE  = 2'd0;
    localparam logic [1:0] ST_SCAN  = 2'd1;
    localparam logic [1:0] ST_SHIFT = 2'd2;

    logic [1:0]       r_state, n_state;
    logic [FW-1:0]    r_fill, n_fill;
    logic             r_remove, n_remove;
    logic [KEY_W-1:0] r_key, n_key;
    logic [AW-1:0]    r_pos, n_pos;
    logic             r_valid, n_valid;
    t_result          r_res, n_res;

    t_walk_ctrl       w_ctrl;
    t_walk_stat       w_stat;
    logic [FW-1:0]    w_base;
    logic [AW-1:0]    w_rd_addr;
    logic [AW-1:0]    w_tag;
    logic [KEY_W-1:0] w_rd_data;
    logic             w_we;
    logic [AW-1:0]    w_waddr;
    logic [KEY_W-1:0] w_wdata;

    // pack a result, masking index and count to their field widths
    function automatic t_result make_result(input logic [1:0]    status,
                                            input logic          found,
                                            input logic [AW-1:0] idx,
                                            input logic [FW-1:0] cnt);
        t_result          res;
        logic [AW+3:0]    pw;
        logic [FW+4:0]    cw;
        pw           = {4'b0000, idx};
        cw           = {5'b00000, cnt};
        res.status   = status;
        res.found    = found;
        res.position = pw[3:0];
        res.count    = cw[4:0];
        return res;
    endfunction

    // list storage
    olafr_ram #(
        .WIDTH (KEY_W),
        .DEPTH (DEPTH)
    ) u_ram (
        .i_clk   (i_clk),
        .i_we    (w_we),
        .i_waddr (w_waddr),
        .i_wdata (w_wdata),
        .i_raddr (w_rd_addr),
        .o_rdata (w_rd_data)
    );

    // shared pointer and comparator
    olafr_walk #(
        .DEPTH (DEPTH)
    ) u_walk (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_ctrl    (w_ctrl),
        .i_base    (w_base),
        .i_limit   (r_fill),
        .i_key     (r_key),
        .i_rd_data (w_rd_data),
        .o_rd_addr (w_rd_addr),
        .o_tag     (w_tag),
        .o_stat    (w_stat)
    );

    // sequence search, shift and result
    always_comb begin
        n_state  = r_state;
        n_fill   = r_fill;
        n_remove = r_remove;
        n_key    = r_key;
        n_pos    = r_pos;
        n_valid  = 1'b0;
        n_res    = r_res;
        w_ctrl   = '0;
        w_base   = '0;
        w_we     = 1'b0;
        w_waddr  = r_fill[AW-1:0];
        w_wdata  = r_key;

        unique case (r_state)
            ST_IDLE: begin
                if (start) begin
                    case (i_req.kind) inside
                        KIND_APPEND: begin
                            n_valid = 1'b1;
                            if (r_fill >= FILL_MAX) begin
                                n_res = make_result(STAT_FULL, 1'b0, '0, r_fill);
                            end else begin
                                w_we    = 1'b1;
                                w_wdata = i_req.key;
                                n_fill  = r_fill + FW'(1);
                                n_res   = make_result(STAT_OK, 1'b1, r_fill[AW-1:0],
                                                      r_fill + FW'(1));
                            end
                        end
                        KIND_FIND, KIND_REMOVE: begin
                            if (r_fill == '0) begin
                                n_valid = 1'b1;
                                n_res   = make_result(STAT_MISSING, 1'b0, '0, r_fill);
                            end else begin
                                w_ctrl.load = 1'b1;
                                n_remove    = (i_req.kind == KIND_REMOVE);
                                n_key       = i_req.key;
                                n_state     = ST_SCAN;
                            end
                        end
                        default: begin
                            n_valid = 1'b1;
                            n_res   = make_result(STAT_OK, 1'b0, '0, r_fill);
                        end
                    endcase
                end
            end
            ST_SCAN: begin
                w_ctrl.run = 1'b1;
                if (w_stat.hit) begin
                    if (r_remove) begin
                        w_ctrl.load = 1'b1;
                        w_base      = FW'(w_tag) + FW'(1);
                        n_pos       = w_tag;
                        n_state     = ST_SHIFT;
                    end else begin
                        n_valid = 1'b1;
                        n_res   = make_result(STAT_OK, 1'b1, w_tag, r_fill);
                        n_state = ST_IDLE;
                    end
                end else if (w_stat.drained) begin
                    n_valid = 1'b1;
                    n_res   = make_result(STAT_MISSING, 1'b0, '0, r_fill);
                    n_state = ST_IDLE;
                end
            end
            ST_SHIFT: begin
                // move each later entry down one place
                w_ctrl.run = 1'b1;
                if (w_stat.pend) begin
                    w_we    = 1'b1;
                    w_waddr = w_tag - AW'(1);
                    w_wdata = w_rd_data;
                end
                if (w_stat.drained) begin
                    n_fill  = r_fill - FW'(1);
                    n_valid = 1'b1;
                    n_res   = make_result(STAT_OK, 1'b1, r_pos, r_fill - FW'(1));
                    n_state = ST_IDLE;
                end
            end
            default: begin
                n_state = ST_IDLE;
            end
        endcase
    end

    // hold control state
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ST_IDLE;
            r_fill  <= '0;
            r_valid <= 1'b0;
        end else begin
            r_state <= n_state;
            r_fill  <= n_fill;
            r_valid <= n_valid;
        end
    end

    // hold request and result payload
    always_ff @(posedge i_clk) begin
        r_remove <= n_remove;
        r_key    <= n_key;
        r_pos    <= n_pos;
        r_res    <= n_res;
    end

    assign busy    = (r_state != ST_IDLE);
    assign o_valid = r_valid;
    assign o_res   = r_res;

`ifndef SYNTHESIS
    // a result is only shown once the sequencer is back at rest
    assert property (@(posedge i_clk) disable iff (!i_rst_n) o_valid |-> !busy)
        else $error("result shown while busy");

    // the list never holds more than its depth
    assert property (@(posedge i_clk) disable iff (!i_rst_n) r_fill <= FILL_MAX)
        else $error("fill count beyond depth");

    // an append finishes in the next cycle
    assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (start && !busy && i_req.kind == KIND_APPEND) |=> o_valid)
        else $error("append gave no result in the next cycle");

    // a completed remove leaves one entry fewer
    assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == ST_SHIFT && w_stat.drained) |=> (r_fill == $past(r_fill) - FW'(1)))
        else $error("remove did not shorten the list");
`endif

endmodule

### bench/ordered_list_append_find_remove_top_tb.sv
// ----------------------------------------------------------------------------
// Ordered key list testbench
// Drives append, find and remove items through the start/busy handshake,
// first from a short directed table, then at random with fill sweeps, and
// checks every strobed result field by field against the list model or table.
// ----------------------------------------------------------------------------
module ordered_list_append_find_remove_top_tb;

    import olafr_pkg::*;

    localparam int         LIST_DEPTH  = OLAFR_DEPTH;
    localparam logic [1:0] KIND_UNUSED = 2'd3;
    localparam int         RANDOM_ITEMS = 1700;
    localparam int         MAX_GAP     = 11;

    // one row of the directed table
    typedef struct {
        logic [1:0]  kind;
        logic [31:0] key;
        int          reps;
        bit          typed;
        t_result     res;
    } t_stim_row;

    logic     i_clk   = 1'b0;
    logic     i_rst_n = 1'b0;
    logic     start   = 1'b0;
    t_request i_req   = '0;
    logic     busy;
    logic     o_valid;
    t_result  o_res;

    // list model state
    bit [31:0] list_entries [LIST_DEPTH];
    int        list_fill = 0;

    t_result   pending_results [$];
    t_stim_row stim_table [$];
    int        mismatch_count = 0;

    ordered_list_append_find_remove_top #(
        .DEPTH(LIST_DEPTH)
    ) DUT (
        .i_clk  (i_clk),
        .i_rst_n(i_rst_n),
        .start  (start),
        .i_req  (i_req),
        .busy   (busy),
        .o_valid(o_valid),
        .o_res  (o_res)
    );

    always #5 i_clk = ~i_clk;

    // apply one request to the list model and return its result
    function automatic t_result predict_request(input t_request req);
        t_result r;
        int      hit;
        int      i;
        r   = '0;
        hit = -1;
        case (req.kind)
            KIND_APPEND: begin
                if (list_fill >= LIST_DEPTH) begin
                    r.status = STAT_FULL;
                end else begin
                    list_entries[list_fill] = req.key;
                    r.found    = 1'b1;
                    r.position = 4'(list_fill);
                    list_fill++;
                end
            end
            KIND_FIND, KIND_REMOVE: begin
                // lowest index wins on duplicate keys
                for (i = 0; i < list_fill; i++) begin
                    if (hit < 0 && list_entries[i] == req.key)
                        hit = i;
                end
                if (hit < 0) begin
                    r.status = STAT_MISSING;
                end else begin
                    r.found    = 1'b1;
                    r.position = 4'(hit);
                    if (req.kind == KIND_REMOVE) begin
                        for (i = hit; i + 1 < list_fill; i++)
                            list_entries[i] = list_entries[i + 1];
                        list_fill--;
                    end
                end
            end
            default: ;
        endcase
        r.count = 5'(list_fill);
        return r;
    endfunction

    function automatic t_result mk_result(input logic [1:0] status, input int found,
                                          input int position, input int count);
        t_result r;
        r.status   = status;
        r.found    = 1'(found);
        r.position = 4'(position);
        r.count    = 5'(count);
        return r;
    endfunction

    task automatic add_row(input logic [1:0] kind, input logic [31:0] key, input int reps,
                           input int typed, input t_result res);
        t_stim_row row;
        row.kind  = kind;
        row.key   = key;
        row.reps  = reps;
        row.typed = (typed != 0);
        row.res   = res;
        stim_table.push_back(row);
    endtask

    // keep start low through the gap, then present the item until taken
    task automatic send_request(input t_request req, input int gap, input bit typed,
                                input t_result lit);
        t_result want;
        if (gap > 0) begin
            start <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        start <= 1'b1;
        i_req <= req;
        do @(posedge i_clk); while (busy);
        want = predict_request(req);
        if (typed)
            want = lit;
        pending_results.push_back(want);
    endtask

    // drop start and hold until every outstanding result has arrived
    task automatic drain_results();
        start <= 1'b0;
        do @(posedge i_clk); while (pending_results.size() != 0);
    endtask

    // pick a key: mostly ones held in the list or a small colliding pool
    function automatic logic [31:0] pick_key();
        int r;
        r = $urandom_range(0, 99);
        if (list_fill > 0 && r < 55)
            return list_entries[$urandom_range(0, list_fill - 1)];
        if (r < 80)
            return 32'hC0DE_0000 ^ 32'($urandom_range(0, 5));
        return $urandom;
    endfunction

    // check each strobed result against the oldest expectation
    always @(posedge i_clk) begin : check_results
        t_result want;
        if (i_rst_n && o_valid) begin
            if (pending_results.size() == 0) begin
                $error("unexpected result: status %0d found %0d position %0d count %0d",
                       o_res.status, o_res.found, o_res.position, o_res.count);
                mismatch_count++;
            end else begin
                want = pending_results.pop_front();
                if (o_res.status !== want.status) begin
                    $error("status: expected %0d, got %0d", want.status, o_res.status);
                    mismatch_count++;
                end
                if (o_res.found !== want.found) begin
                    $error("found: expected %0d, got %0d", want.found, o_res.found);
                    mismatch_count++;
                end
                if (o_res.position !== want.position) begin
                    $error("position: expected %0d, got %0d", want.position, o_res.position);
                    mismatch_count++;
                end
                if (o_res.count !== want.count) begin
                    $error("count: expected %0d, got %0d", want.count, o_res.count);
                    mismatch_count++;
                end
            end
        end
    end

    // stimulus
    initial begin : stimulus
        t_request req;
        int       sent;
        int       append_pct;
        bit       burst;
        int       r;
        int       gap;

        // empty list and unused kind, then duplicates, fill to full, drain ends
        add_row(KIND_FIND,   32'h0000_0000, 1, 1, mk_result(STAT_MISSING, 0, 0, 0));
        add_row(KIND_REMOVE, 32'h0000_0005, 1, 1, mk_result(STAT_MISSING, 0, 0, 0));
        add_row(KIND_UNUSED, 32'hFFFF_FFFF, 1, 1, mk_result(STAT_OK, 0, 0, 0));
        add_row(KIND_APPEND, 32'h8000_0000, 1, 1, mk_result(STAT_OK, 1, 0, 1));
        add_row(KIND_APPEND, 32'h7FFF_FFFF, 1, 1, mk_result(STAT_OK, 1, 1, 2));
        add_row(KIND_APPEND, 32'h7FFF_FFFF, 1, 1, mk_result(STAT_OK, 1, 2, 3));
        add_row(KIND_FIND,   32'h7FFF_FFFF, 1, 1, mk_result(STAT_OK, 1, 1, 3));
        add_row(KIND_REMOVE, 32'h7FFF_FFFF, 1, 0, '0);
        add_row(KIND_FIND,   32'h7FFF_FFFF, 1, 0, '0);
        add_row(KIND_FIND,   32'h1234_5678, 1, 1, mk_result(STAT_MISSING, 0, 0, 2));
        add_row(KIND_APPEND, 32'hFFFF_FFF4, 13, 0, '0);
        add_row(KIND_APPEND, 32'h5A5A_5A5A, 1, 1, mk_result(STAT_OK, 1, 15, 16));
        add_row(KIND_APPEND, 32'h0000_0001, 1, 1, mk_result(STAT_FULL, 0, 0, 16));
        add_row(KIND_FIND,   32'h0000_0000, 1, 0, '0);
        add_row(KIND_REMOVE, 32'h8000_0000, 1, 0, '0);
        add_row(KIND_REMOVE, 32'h5A5A_5A5A, 1, 0, '0);
        add_row(KIND_UNUSED, 32'h0000_0000, 1, 0, '0);

        // hold reset low, then release it
        repeat (2) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // walk the directed table; repeated rows step the key by one
        foreach (stim_table[n]) begin
            for (int k = 0; k < stim_table[n].reps; k++) begin
                req.kind = stim_table[n].kind;
                req.key  = stim_table[n].key + 32'(k);
                send_request(req, $urandom_range(0, MAX_GAP), stim_table[n].typed,
                             stim_table[n].res);
            end
        end
        drain_results();

        // random part: phases that push the fill up, hold it, or drain it
        sent       = 0;
        append_pct = 50;
        burst      = 1'b0;
        while (sent < RANDOM_ITEMS) begin
            if (sent % 64 == 0) begin
                r          = $urandom_range(0, 2);
                append_pct = (r == 0) ? 15 : (r == 1) ? 50 : 85;
                burst      = ($urandom_range(0, 3) == 0);
            end
            if (sent == RANDOM_ITEMS / 2)
                drain_results();
            r = $urandom_range(0, 99);
            if (r < 2) begin
                req.kind = KIND_UNUSED;
            end else if (r < 2 + append_pct) begin
                req.kind = KIND_APPEND;
                sent++;
            end else begin
                req.kind = $urandom_range(0, 1) ? KIND_FIND : KIND_REMOVE;
                sent++;
            end
            req.key = pick_key();
            gap     = burst ? 0 : $urandom_range(0, MAX_GAP);
            send_request(req, gap, 1'b0, '0);
        end

        // wait out the last results, then allow for any stray strobe
        drain_results();
        repeat (2 * LIST_DEPTH + 8) @(posedge i_clk);

        if (mismatch_count == 0) begin
            $display("ordered_list_append_find_remove_top_tb OK");
        end else begin
            $display("ordered_list_append_find_remove_top_tb NOT OK");
        end
        $finish;
    end

    // end a hung run
    initial begin : watchdog
        #20000000;
        $display("ordered_list_append_find_remove_top_tb NOT OK");
        $finish;
    end

endmodule

### files.f
src/olafr_pkg.sv
src/olafr_ram.sv
src/olafr_walk.sv
src/ordered_list_append_find_remove_top.sv
bench/ordered_list_append_find_remove_top_tb.sv
